/* sv/lge_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types, sizes and the B3/S23 cell rule for the life grid engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 7;   // size registers, wide enough to hold the maxima
  localparam int CFG_W  = 7;
  localparam int GEN_W  = 32;

  // register indexes of the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [MAX_WIDTH-1:0] row_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV_FIRST,
    ST_ADV_ROW,
    ST_FINISH
  } lge_state_e;

  // three neighboring rows around the row being computed
  typedef struct packed {
    row_t above;
    row_t center;
    row_t below;
  } lge_window_t;

  // map a written size onto 1..max
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(v);
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (SIZE_W'(v) > max) begin
      r = max;
    end
    return r;
  endfunction

  // B3/S23: live with two or three neighbors, born with exactly three
  function automatic logic life_rule(input logic alive, input logic [3:0] n);
    logic r;
    r = (n == 4'd3) || (alive && (n == 4'd2));
    return r;
  endfunction

endpackage

/* sv/life_automaton_grid_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_grid_engine
// Game of Life (B3/S23) grid engine on a row-wide grid memory with one read and one write port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one op per transfer: write a
//   cell, read a cell, clear grid and count, or advance one generation. Each
//   op yields exactly one result transfer on the output channel
//   (out_valid_o/out_ready_i): cell_out_o, generation_o, out_of_range_o.
//   The grid lives in a 64-row by 64-bit memory, one row per entry, with a
//   registered read. Steps from input transfer to result valid:
//     clear or out-of-range access : straight to the result register
//     in-range read or write       : read row, modify, write back, result
//     advance                      : fetch row 0, then each row in use, result
//   An advance streams the grid one row per cycle through a three-row window
//   and writes each new row back in place; the row memory port sets that rate.
//   One op at a time: the engine returns to idle when the result is loaded
//   and then takes the next op, even while that result is stalled.
//   A stalled receiver holds the result; a finished op waits in its last
//   state until the result register frees up.
//   Reset empties the grid at once (per-row valid bits read as dead rows),
//   zeroes the generation count and sets both sizes to 64. No clearing pass.
//   Configuration writes (cfg_we_i) take effect at once and are meant only
//   while the block is idle.
// ----------------------------------------------------------------------------
module life_automaton_grid_engine
  import lge_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [COL_W-1:0] col_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic             cell_in_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             cell_out_o,
  output logic [GEN_W-1:0] generation_o,
  output logic             out_of_range_o
);

  // configuration
  logic [CFG_W-1:0]  width_q, height_q;
  logic [SIZE_W-1:0] w_eff, h_eff;
  row_t              col_mask;

  // control
  lge_state_e        state_q, state_d;
  logic [GEN_W-1:0]  gen_q;
  logic [MAX_HEIGHT-1:0] row_vld_q;
  logic              rd_vld_q;
  logic              out_valid_q;

  // latched op
  op_e               op_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              val_q;
  logic              res_cell_q, res_oor_q;

  // advance window
  row_t              prev_q, cur_q;
  logic [ROW_W-1:0]  r_q;

  // memory
  row_t              mem_q [MAX_HEIGHT];
  row_t              rd_data_q;
  row_t              rd_row;
  logic              rd_en, mem_we;
  logic [ROW_W-1:0]  rd_addr, wr_addr;
  row_t              wr_data;

  logic              in_xfer, in_range, is_cell_op;
  logic              has_next, has_next2, last_row;
  logic [SIZE_W-1:0] r_plus1, r_plus2;
  row_t              below, calc_row, adv_row, cell_row;
  lge_window_t       win;
  logic              finish_go;

  // --------------------------------------------------------------------------
  // Configuration registers and effective sizes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(MAX_WIDTH);
      height_q <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign w_eff = clamp_size(width_q, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));

  // one bit per column in use
  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      col_mask[c] = (SIZE_W'(c) < w_eff);
    end
  end

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_cell_op = (op_i inside {OP_WRITE, OP_READ});
  assign in_range   = (SIZE_W'(col_i) < w_eff) && (SIZE_W'(row_i) < h_eff);

  // --------------------------------------------------------------------------
  // Row memory: one row per entry, registered read; rows not yet written
  // since reset or clear read as all dead through their valid bit.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en) begin
      rd_vld_q <= row_vld_q[rd_addr];
    end
  end

  assign rd_row = rd_data_q & {MAX_WIDTH{rd_vld_q}};

  // --------------------------------------------------------------------------
  // Advance datapath: rows r-1, r in registers, row r+1 from memory
  // --------------------------------------------------------------------------
  assign r_plus1   = SIZE_W'(r_q) + SIZE_W'(1);
  assign r_plus2   = SIZE_W'(r_q) + SIZE_W'(2);
  assign has_next  = (r_plus1 < h_eff);
  assign has_next2 = (r_plus2 < h_eff);
  assign last_row  = !has_next;
  assign below     = has_next ? rd_row : '0;

  // columns beyond the width count as dead neighbors
  assign win.above  = prev_q & col_mask;
  assign win.center = cur_q & col_mask;
  assign win.below  = below & col_mask;

  lge_row_calc u_row_calc (
    .win_i (win),
    .row_o (calc_row)
  );

  // keep the stored bits of columns outside the width
  assign adv_row = (calc_row & col_mask) | (cur_q & ~col_mask);

  // single-cell update of the fetched row
  always_comb begin
    cell_row        = rd_row;
    cell_row[col_q] = val_q;
  end

  assign finish_go = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = row_i;
    mem_we  = 1'b0;
    wr_addr = r_q;
    wr_data = adv_row;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (is_cell_op) begin
            if (in_range) begin
              rd_en   = 1'b1;
              state_d = ST_CELL;
            end else begin
              state_d = ST_FINISH;
            end
          end else if (op_i == OP_ADVANCE) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_ADV_FIRST;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_CELL: begin
        // write back the modified row; a read only samples it
        mem_we  = (op_q == OP_WRITE);
        wr_addr = row_q;
        wr_data = cell_row;
        state_d = ST_FINISH;
      end
      ST_ADV_FIRST: begin
        // row 0 arrives now; fetch row 1 ahead
        rd_en   = (h_eff > SIZE_W'(1));
        rd_addr = ROW_W'(1);
        state_d = ST_ADV_ROW;
      end
      ST_ADV_ROW: begin
        // write row r in place, fetch row r+2; never the same entry
        mem_we  = 1'b1;
        wr_addr = r_q;
        wr_data = adv_row;
        rd_en   = has_next2;
        rd_addr = r_plus2[ROW_W-1:0];
        if (last_row) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers (no reset needed)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q       <= op_e'(op_i);
      col_q      <= col_i;
      row_q      <= row_i;
      val_q      <= cell_in_i;
      res_cell_q <= 1'b0;
      res_oor_q  <= is_cell_op && !in_range;
    end
    case (state_q)
      ST_CELL: begin
        res_cell_q <= (op_q == OP_READ) ? rd_row[col_q] : 1'b0;
      end
      ST_ADV_FIRST: begin
        prev_q <= '0;
        cur_q  <= rd_row;
        r_q    <= '0;
      end
      ST_ADV_ROW: begin
        prev_q <= cur_q;
        cur_q  <= below;
        r_q    <= r_q + ROW_W'(1);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers: row valid bits and generation count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      gen_q     <= '0;
    end else begin
      if (in_xfer && (op_i == OP_CLEAR)) begin
        row_vld_q <= '0;
        gen_q     <= '0;
      end else begin
        if (mem_we) begin
          row_vld_q[wr_addr] <= 1'b1;
        end
        if ((state_q == ST_ADV_ROW) && last_row) begin
          gen_q <= gen_q + GEN_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FINISH) && finish_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && finish_go) begin
      cell_out_o     <= res_cell_q;
      generation_o   <= gen_q;
      out_of_range_o <= res_oor_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_we)
    else $error("grid memory written while idle");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same row in one cycle");

  a_row_in_use : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV_ROW) |-> (SIZE_W'(r_q) < h_eff))
    else $error("advance row beyond rows in use");

  a_clear_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (op_i == OP_CLEAR)) |=> (gen_q == '0) && (row_vld_q == '0))
    else $error("clear did not reset grid and count");

endmodule

/* sv/lge_row_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_row_calc
// One lane per column: counts the eight neighbors and applies the rule.
// ----------------------------------------------------------------------------
module lge_row_calc
  import lge_pkg::*;
(
  input  lge_window_t win_i,
  output row_t        row_o
);

  // pad with a dead column on each side so edge lanes see dead neighbors
  logic [MAX_WIDTH+1:0] above_ext;
  logic [MAX_WIDTH+1:0] center_ext;
  logic [MAX_WIDTH+1:0] below_ext;

  assign above_ext  = {1'b0, win_i.above, 1'b0};
  assign center_ext = {1'b0, win_i.center, 1'b0};
  assign below_ext  = {1'b0, win_i.below, 1'b0};

  always_comb begin
    logic [3:0] n;
    row_o = '0;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      n = 4'(above_ext[c]) + 4'(above_ext[c+1]) + 4'(above_ext[c+2])
        + 4'(center_ext[c]) + 4'(center_ext[c+2])
        + 4'(below_ext[c]) + 4'(below_ext[c+1]) + 4'(below_ext[c+2]);
      row_o[c] = life_rule(win_i.center[c], n);
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Game of Life (B3/S23) grid engine.
// ----------------------------------------------------------------------------
// A queue of grid ops feeds a valid/ready driver. Every accepted op is run
// through a bit-level grid model in the bench, which queues the readout it
// must produce. A monitor with random back-pressure compares each readout
// transfer field by field against the oldest queued one. The run starts with
// directed ops at the reset size (corner and edge patterns, no-wrap checks),
// then walks through a series of grid sizes, including out-of-range register
// values, with random seeding, advances, reads, out-of-range accesses and
// clears. Between sizes the bench drains all results before it reconfigures.
// ----------------------------------------------------------------------------
module tb_top;
  import lge_pkg::*;

  localparam int IDLE_LIMIT = 5000;   // cycles with no transfer on either side

  typedef struct {
    op_e             op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic            cell_val;
  } grid_op_t;

  typedef struct {
    logic             alive;
    logic [GEN_W-1:0] gen;
    logic             oor;
  } readout_t;

  // DUT connections; every input starts at a known value
  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic             cfg_idx_i  = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       op_i       = OP_READ;
  logic [COL_W-1:0] col_i      = '0;
  logic [ROW_W-1:0] row_i      = '0;
  logic             cell_in_i  = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             cell_out_o;
  logic [GEN_W-1:0] generation_o;
  logic             out_of_range_o;

  // grid model state
  logic [MAX_WIDTH-1:0] grid_ref [MAX_HEIGHT];
  logic [GEN_W-1:0]     gen_ref  = '0;
  logic [CFG_W-1:0]     cols_reg = CFG_W'(64);
  logic [CFG_W-1:0]     rows_reg = CFG_W'(64);

  grid_op_t op_q[$];        // ops waiting to be driven
  readout_t readout_q[$];   // readouts the DUT still owes

  bit steady = 1'b0;        // when set, neither side idles
  int err_count  = 0;
  int n_ops      = 0;
  int n_checked  = 0;
  int n_advances = 0;
  int n_oor      = 0;
  int n_clears   = 0;
  int n_sizes    = 1;

  life_automaton_grid_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .cell_in_i     (cell_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_out_o    (cell_out_o),
    .generation_o  (generation_o),
    .out_of_range_o(out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Grid model
  // --------------------------------------------------------------------------

  // Map a size register onto the span actually used: zero acts as one,
  // anything past the maximum acts as the maximum.
  function automatic int size_used(input logic [CFG_W-1:0] v, input int max);
    if (v == '0) return 1;
    if (int'(v) > max) return max;
    return int'(v);
  endfunction

  // Compute one generation over the in-use window only; cells beyond the
  // window count as dead and keep whatever they hold.
  task automatic advance_grid();
    logic [MAX_WIDTH-1:0] nxt [MAX_HEIGHT];
    int w, h, n, rr, cc;
    w = size_used(cols_reg, MAX_WIDTH);
    h = size_used(rows_reg, MAX_HEIGHT);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w) begin
              n += int'(grid_ref[rr][cc]);
            end
          end
        end
        nxt[r][c] = (n == 3) || (grid_ref[r][c] && n == 2);
      end
    end
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        grid_ref[r][c] = nxt[r][c];
      end
    end
    gen_ref = gen_ref + GEN_W'(1);
  endtask

  // Apply one accepted op to the model and queue the readout it must produce.
  task automatic predict_grid_op(input grid_op_t it);
    readout_t ro;
    bit       in_grid;
    ro.alive = 1'b0;
    ro.oor   = 1'b0;
    in_grid = (int'(it.col) < size_used(cols_reg, MAX_WIDTH)) &&
              (int'(it.row) < size_used(rows_reg, MAX_HEIGHT));
    case (it.op)
      OP_WRITE, OP_READ: begin
        if (!in_grid) begin
          ro.oor = 1'b1;
          n_oor++;
        end else if (it.op == OP_WRITE) begin
          grid_ref[it.row][it.col] = it.cell_val;
        end else begin
          ro.alive = grid_ref[it.row][it.col];
        end
      end
      OP_ADVANCE: begin
        advance_grid();
        n_advances++;
      end
      default: begin
        for (int r = 0; r < MAX_HEIGHT; r++) grid_ref[r] = '0;
        gen_ref = '0;
        n_clears++;
      end
    endcase
    ro.gen = gen_ref;
    readout_q.push_back(ro);
    n_ops++;
  endtask

  // --------------------------------------------------------------------------
  // Gap source shared by both sides: mostly back to back, some short gaps,
  // a few long ones.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued ops; hold valid and payload until the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_ops
    grid_op_t on_wire;
    int       send_wait;
    logic     nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        // the op transfers at this edge: predict its readout now
        predict_grid_op(on_wire);
        send_wait = pick_gap();
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (op_q.size() != 0) begin
          on_wire   = op_q.pop_front();
          op_i      <= on_wire.op;
          col_i     <= on_wire.col;
          row_i     <= on_wire.row;
          cell_in_i <= on_wire.cell_val;
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure; check each readout transfer in order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_readouts
    readout_t want;
    int       hold_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (readout_q.size() == 0) begin
          $display("%0t: unexpected readout cell_out=%0b generation=%0d out_of_range=%0b",
                   $time, cell_out_o, generation_o, out_of_range_o);
          err_count++;
        end else begin
          want = readout_q.pop_front();
          n_checked++;
          if (cell_out_o !== want.alive) begin
            $display("%0t: cell_out mismatch: expected %0b, got %0b",
                     $time, want.alive, cell_out_o);
            err_count++;
          end
          if (generation_o !== want.gen) begin
            $display("%0t: generation mismatch: expected %0d, got %0d",
                     $time, want.gen, generation_o);
            err_count++;
          end
          if (out_of_range_o !== want.oor) begin
            $display("%0t: out_of_range mismatch: expected %0b, got %0b",
                     $time, want.oor, out_of_range_o);
            err_count++;
          end
        end
        hold_left = pick_gap();
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready_i <= (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither side transfers for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    int idle_cycles;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d readouts outstanding",
                 $time, IDLE_LIMIT, readout_q.size());
        $display("** life_automaton_grid_engine: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic grid_op_t make_op(input op_e op, input int row, input int col,
                                       input bit v);
    grid_op_t it;
    it.op       = op;
    it.row      = ROW_W'(row);
    it.col      = COL_W'(col);
    it.cell_val = v;
    return it;
  endfunction

  // Block until every queued op has transferred and every readout has come
  // back, then let the engine settle. Sample at the falling edge so the
  // driver's updates at the rising edge are already visible.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_q.size() != 0 || in_valid_i || readout_q.size() != 0);
    repeat (10) @(negedge clk_i);
  endtask

  // Write one size register; only called while the engine is drained.
  task automatic write_size(input logic idx, input int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH) cols_reg = CFG_W'(value);
    else rows_reg = CFG_W'(value);
  endtask

  // Queue a random phase: seed live cells inside the window first, then
  // mix advances with reads, more writes, stray accesses and rare clears.
  task automatic queue_random_phase(input int count);
    int w, h, seeds, r;
    w = size_used(cols_reg, MAX_WIDTH);
    h = size_used(rows_reg, MAX_HEIGHT);
    seeds = $urandom_range(3, 9);
    for (int k = 0; k < count; k++) begin
      r = (k < seeds) ? 0 : $urandom_range(0, 99);
      if (r < 30) begin
        op_q.push_back(make_op(OP_WRITE, $urandom_range(0, h - 1),
                               $urandom_range(0, w - 1), $urandom_range(0, 99) < 60));
      end else if (r < 40) begin
        op_q.push_back(make_op(OP_WRITE, $urandom, $urandom, 1'($urandom)));
      end else if (r < 65) begin
        op_q.push_back(make_op(OP_ADVANCE, $urandom, $urandom, 1'($urandom)));
      end else if (r < 88) begin
        op_q.push_back(make_op(OP_READ, $urandom_range(0, h - 1),
                               $urandom_range(0, w - 1), 1'($urandom)));
      end else if (r < 97) begin
        op_q.push_back(make_op(OP_READ, $urandom, $urandom, 1'($urandom)));
      end else begin
        op_q.push_back(make_op(OP_CLEAR, $urandom, $urandom, 1'($urandom)));
      end
    end
  endtask

  initial begin : run_test
    int size_w [11];
    int size_h [11];
    for (int r = 0; r < MAX_HEIGHT; r++) grid_ref[r] = '0;

    // hold reset, then release it at a rising edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset size (64 x 64).
    // Read fresh corners, build an L in the top-left corner that grows into
    // a block without wrapping, and a blinker along the bottom edge.
    op_q.push_back(make_op(OP_READ,  0,  0, 1'b1));
    op_q.push_back(make_op(OP_READ,  63, 63, 1'b0));
    op_q.push_back(make_op(OP_WRITE, 0,  0, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 0,  1, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 1,  0, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 63, 61, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 63, 62, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 63, 63, 1'b1));
    op_q.push_back(make_op(OP_ADVANCE, 0, 0, 1'b0));
    op_q.push_back(make_op(OP_READ,  1,  1, 1'b0));
    op_q.push_back(make_op(OP_READ,  0,  0, 1'b0));
    op_q.push_back(make_op(OP_READ,  62, 62, 1'b0));
    op_q.push_back(make_op(OP_READ,  63, 61, 1'b0));
    op_q.push_back(make_op(OP_ADVANCE, 63, 63, 1'b1));
    op_q.push_back(make_op(OP_READ,  63, 62, 1'b0));
    op_q.push_back(make_op(OP_WRITE, 0,  0, 1'b0));
    op_q.push_back(make_op(OP_READ,  0,  0, 1'b0));
    op_q.push_back(make_op(OP_CLEAR, 0,  0, 1'b0));
    op_q.push_back(make_op(OP_READ,  1,  1, 1'b0));
    op_q.push_back(make_op(OP_ADVANCE, 0, 0, 1'b0));
    // leave a few live cells far out so that smaller sizes must keep them
    op_q.push_back(make_op(OP_WRITE, 40, 50, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 2,  2, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 2,  3, 1'b1));
    op_q.push_back(make_op(OP_WRITE, 2,  4, 1'b1));
    wait_drained();

    // Size sweep: zero and oversized values, single rows and columns, the
    // smallest real grid, back to full size, then one random size.
    size_w = '{0, 3,   5, 127, 65, 64, 1,  8, 12, 64, 1};
    size_h = '{0, 3, 127,   5, 64,  1, 64, 8, 16, 64, 1};
    size_w[10] = $urandom_range(1, 64);
    size_h[10] = $urandom_range(1, 64);
    for (int p = 0; p < 11; p++) begin
      write_size(CFG_WIDTH, size_w[p]);
      write_size(CFG_HEIGHT, size_h[p]);
      n_sizes++;
      // every fourth phase or so runs without any idling on either side
      steady = ($urandom_range(0, 3) == 0);
      queue_random_phase($urandom_range(8, 13));
      // pause the sender until every readout is back
      wait_drained();
    end

    if (readout_q.size() != 0) begin
      $display("%0t: %0d readouts never arrived", $time, readout_q.size());
      err_count++;
    end
    $display("Covered %0d ops (%0d advances, %0d out-of-range accesses, %0d clears)",
             n_ops, n_advances, n_oor, n_clears);
    $display("over %0d grid sizes; %0d readouts checked, %0d mismatches.",
             n_sizes, n_checked, err_count);
    if (err_count == 0) begin
      $display("** life_automaton_grid_engine: PASSED **");
    end else begin
      $display("** life_automaton_grid_engine: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
sv/lge_pkg.sv
sv/lge_row_calc.sv
sv/life_automaton_grid_engine.sv
test/tb_top.sv
